// ----- sv/d2h_pkg.sv -----
// Shared types, character codes and helpers for the decimal-to-hex text rewriter.
package d2h_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] CHAR_X    = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_A    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PFX0  = 6'b000010,
    ST_PFX1  = 6'b000100,
    ST_SKIP  = 6'b001000,
    ST_DIG   = 6'b010000,
    ST_TAIL  = 6'b100000
  } state_t;

  // Source of the byte written into the output register.
  typedef enum logic [2:0] {
    SEL_IN   = 3'd0,  // live input transaction
    SEL_HELD = 3'd1,  // latched ending byte, pass-through byte or end marker
    SEL_ZERO = 3'd2,
    SEL_X    = 3'd3,
    SEL_HEX  = 3'd4
  } emit_sel_t;

  typedef struct packed {
    logic      acc_digit;    // fold incoming digit into accumulator
    logic      start_flush;  // move accumulator into nibble shifter, clear run
    logic      latch_item;   // hold input transaction for later emission
    logic      shift;        // advance to next nibble
    logic      emit;         // load output register
    emit_sel_t emit_sel;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_digit;
    logic pending;
    logic top_zero;
    logic cnt_zero;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_A + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

// ----- sv/d2h_ctrl.sv -----
// Controller state machine: sequences prefix, hex digits and the ending byte.
module d2h_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  d2h_pkg::ctrl_sts_t sts,
  output d2h_pkg::ctrl_cmd_t cmd
);
  import d2h_pkg::*;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_sel = SEL_IN;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_cmd && sts.in_is_digit) begin
            cmd.acc_digit = 1'b1;
          end else if (sts.pending) begin
            cmd.start_flush = 1'b1;
            cmd.latch_item  = 1'b1;
            state_nxt       = ST_PFX0;
          end else if (sts.out_free) begin
            // pass-through byte or bare end marker goes out directly
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_IN;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.latch_item = 1'b1;
            state_nxt      = ST_TAIL;
          end
        end
      end
      ST_PFX0: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_ZERO;
          state_nxt    = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_X;
          state_nxt    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero nibbles; the last nibble always prints
        if (sts.top_zero && !sts.cnt_zero) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_HEX;
          cmd.shift    = 1'b1;
          state_nxt    = sts.cnt_zero ? ST_TAIL : ST_DIG;
        end
      end
      ST_DIG: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_HEX;
          cmd.shift    = 1'b1;
          if (sts.cnt_zero) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_HELD;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/d2h_datapath.sv -----
// Datapath: decimal accumulator, nibble shifter, held transaction and output register.
module d2h_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_cmd,
  input  logic [7:0]         in_text_byte,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_is_end,
  output logic               out_last_of_run,
  input  d2h_pkg::ctrl_cmd_t cmd,
  output d2h_pkg::ctrl_sts_t sts
);
  import d2h_pkg::*;

  localparam int NIBBLES = (VALUE_BITS + 3) / 4;
  localparam int SH_W    = NIBBLES * 4;
  localparam int CNT_W   = (NIBBLES > 1) ? $clog2(NIBBLES) : 1;
  localparam int EXT_W   = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  pending_r;
  logic [SH_W-1:0]       sh_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  held_cmd_r;
  logic [7:0]            held_byte_r;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_is_end_r, out_is_end_nxt;
  logic                  out_last_r;

  logic [7:0]       byte_off;
  logic [EXT_W-1:0] acc_ext, prod;
  logic             ovf;
  logic [3:0]       top_nib;

  assign byte_off = in_text_byte - CHAR_ZERO;
  assign acc_ext  = EXT_W'(acc_r);
  // acc*10 + digit; any carry into the top nibble means overflow
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(byte_off[3:0]);
  assign ovf      = |prod[EXT_W-1:VALUE_BITS];
  assign acc_nxt  = ovf ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];
  assign top_nib  = sh_r[SH_W-1 -: 4];

  assign sts.in_is_digit = (in_text_byte >= CHAR_ZERO) && (in_text_byte <= CHAR_NINE);
  assign sts.pending     = pending_r;
  assign sts.top_zero    = (top_nib == 4'd0);
  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pending_r <= 1'b0;
    end else if (cmd.acc_digit) begin
      acc_r     <= acc_nxt;
      pending_r <= 1'b1;
    end else if (cmd.start_flush) begin
      acc_r     <= '0;
      pending_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_flush) begin
      sh_r  <= SH_W'(acc_r);
      cnt_r <= CNT_W'(NIBBLES - 1);
    end else if (cmd.shift) begin
      sh_r  <= {sh_r[SH_W-5:0], 4'd0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.latch_item) begin
      held_cmd_r  <= in_cmd;
      held_byte_r <= in_text_byte;
    end
  end

  always_comb begin
    out_byte_nxt   = CHAR_NUL;
    out_is_end_nxt = 1'b0;
    case (cmd.emit_sel)
      SEL_IN: begin
        out_byte_nxt   = in_cmd ? CHAR_NUL : in_text_byte;
        out_is_end_nxt = in_cmd;
      end
      SEL_HELD: begin
        out_byte_nxt   = held_cmd_r ? CHAR_NUL : held_byte_r;
        out_is_end_nxt = held_cmd_r;
      end
      SEL_ZERO: out_byte_nxt = CHAR_ZERO;
      SEL_X:    out_byte_nxt = CHAR_X;
      SEL_HEX:  out_byte_nxt = hex_char(top_nib);
      default:  out_byte_nxt = CHAR_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r   <= out_byte_nxt;
      out_is_end_r <= out_is_end_nxt;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_end      = out_is_end_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- sv/decimal_to_hex_text_rewriter_unit.sv -----
// Top level of the decimal-to-hex text rewriter.
// Text bytes enter one transaction at a time. Digit bytes are taken one per cycle, plain bytes
// with no open number likewise while the output register is free; a digit only updates the
// accumulator, a plain byte or a bare end marker goes straight into the output register (or,
// if it is full, is held and sent from the tail state), which decouples the two sides. An
// ending byte or end marker that closes a digit run holds the input while the controller
// walks the nibble shifter one nibble per cycle while the output is not stalled, emitting
// "0x", the digits, then the ending byte; the hex digits printed and the leading zero nibbles
// skipped number ceil(VALUE_BITS/4). Overflow of the VALUE_BITS accumulator saturates to all ones.
module decimal_to_hex_text_rewriter_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic       out_last_of_run
);
  import d2h_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  d2h_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  d2h_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_text_byte    (in_text_byte),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_is_end      (out_is_end),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- sv/d2h_checker.sv -----
// Port-level checker for the rewriter and its bind to the top level.
module d2h_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_end,
  input logic       out_last_of_run
);
  import d2h_pkg::*;

  // a result waiting on the output holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_is_end)
      && $stable(out_last_of_run))
    else $error("output transaction changed while stalled");

  // end marker is always the last result of its transaction and carries a zero byte
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_last_of_run && (out_byte == CHAR_NUL))
    else $error("malformed end marker");

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // a result that is not the last of its transaction keeps the input blocked
  a_mid_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("input accepted in the middle of a number");

endmodule

bind decimal_to_hex_text_rewriter_unit d2h_checker u_d2h_checker (.*);

// ----- verif/tb_decimal_to_hex_text_rewriter_unit.sv -----
// Testbench for the decimal-to-hex text rewriter: directed table, random text, scoreboard.
`timescale 1ns / 1ps

module tb_decimal_to_hex_text_rewriter_unit;
  import d2h_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int NIBBLES      = (VALUE_BITS + 3) / 4;
  localparam int MAX_RES      = 3 + NIBBLES;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 200;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    logic       run_end;
  } out_txn_t;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
    bit         typed;
    logic [7:0] t_ch;
    logic       t_end;
  } dir_row_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_cmd       = 1'b0;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_ready    = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        out_is_end;
  wire        out_last_of_run;

  always #5 clk = ~clk;

  decimal_to_hex_text_rewriter_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_end     (out_is_end),
    .out_last_of_run(out_last_of_run)
  );

  // Predictor state
  logic [VALUE_BITS-1:0] run_value;
  logic                  run_open;
  out_txn_t              step_res [MAX_RES];
  int                    step_cnt;
  out_txn_t              exp_chars[$];
  dir_row_t              dir_tab[$];

  int err_cnt, n_items, n_checked, n_flushes, n_ends, sat_digits;
  int snd_idle_pct, rcv_stall_pct;
  int hold_reqs, hold_seen, hold_left;
  int idle_cycles;
  int digits_left;

  function automatic void put_char(input logic [7:0] c, input logic e);
    step_res[step_cnt] = out_txn_t'{ch: c, is_end: e, run_end: 1'b0};
    step_cnt++;
  endfunction

  // "0x", hex digits without leading zeros (at least one), then clear the run
  function automatic void flush_run();
    logic [3:0] nib;
    bit         started;
    started = 1'b0;
    put_char(CHAR_ZERO, 1'b0);
    put_char(CHAR_X, 1'b0);
    for (int i = NIBBLES - 1; i >= 0; i--) begin
      nib = run_value[i*4 +: 4];
      if (nib != 4'd0 || started || i == 0) begin
        started = 1'b1;
        put_char((nib < 4'd10) ? CHAR_ZERO + {4'd0, nib} : CHAR_A + {4'd0, nib} - 8'd10, 1'b0);
      end
    end
    run_value = '0;
    run_open  = 1'b0;
    n_flushes++;
  endfunction

  function automatic void rewrite_step(input logic cmd, input logic [7:0] b);
    logic [VALUE_BITS-1:0] d;
    logic [VALUE_BITS-1:0] lim;
    step_cnt = 0;
    if (cmd == CMD_END) begin
      if (run_open) flush_run();
      put_char(CHAR_NUL, 1'b1);
      step_res[step_cnt-1].run_end = 1'b1;
      run_value = '0;
      run_open  = 1'b0;
      n_ends++;
    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      d      = '0;
      d[3:0] = b[3:0];
      lim    = ({VALUE_BITS{1'b1}} - d) / 10;
      if (run_value > lim) begin
        run_value = {VALUE_BITS{1'b1}};
        sat_digits++;
      end else begin
        run_value = run_value * 10 + d;
      end
      run_open = 1'b1;
    end else begin
      if (run_open) flush_run();
      put_char(b, 1'b0);
      step_res[step_cnt-1].run_end = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic cmd, input logic [7:0] c, input bit typed,
                                  input logic [7:0] tc, input logic te);
    dir_row_t r;
    r.cmd   = cmd;
    r.ch    = c;
    r.typed = typed;
    r.t_ch  = tc;
    r.t_end = te;
    dir_tab.push_back(r);
  endfunction

  // Offer one transaction; on acceptance, queue what it should produce
  task automatic send_item(input logic cmd, input logic [7:0] b, input bit typed,
                           input logic [7:0] t_ch, input logic t_end);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rewrite_step(cmd, b);
    if (typed) begin
      exp_chars.push_back(out_txn_t'{ch: t_ch, is_end: t_end, run_end: 1'b1});
    end else begin
      for (int k = 0; k < step_cnt; k++) exp_chars.push_back(step_res[k]);
    end
    n_items++;
  endtask

  // Mostly digit runs between separators, some end markers and raw bytes
  task automatic send_random();
    logic       cmd;
    logic [7:0] b;
    int         r;
    cmd = CMD_TEXT;
    b   = 8'h00;
    if (digits_left > 0) begin
      b = CHAR_ZERO + 8'($urandom_range(9));
      digits_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 40) begin
        // occasional long run to drive the accumulator into saturation
        digits_left = ($urandom_range(9) == 0) ? $urandom_range(14, 10) : $urandom_range(5, 0);
        b = CHAR_ZERO + 8'($urandom_range(9));
      end else if (r < 48) begin
        cmd = CMD_END;
        b   = 8'($urandom_range(255));
      end else if (r < 75) begin
        b = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0:       b = 8'h20;  // space
          1:       b = 8'h2c;  // comma
          2:       b = 8'h0a;  // newline
          default: b = 8'h2e;  // period
        endcase
      end
    end
    send_item(cmd, b, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic run_phase(input int snd, input int rcv, input int count);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    repeat (count) send_random();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Scoreboard
  always @(posedge clk) begin
    out_txn_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got byte %02h end %0b last %0b",
                   $time, out_byte, out_is_end, out_last_of_run);
      end else begin
        e = exp_chars.pop_front();
        n_checked++;
        if (out_byte !== e.ch || out_is_end !== e.is_end || out_last_of_run !== e.run_end) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: mismatch: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                     $time, e.ch, e.is_end, e.run_end, out_byte, out_is_end, out_last_of_run);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, exp_chars.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    run_value   = '0;
    run_open    = 1'b0;
    digits_left = 0;

    // plain bytes and bare end markers: one result each, known by inspection
    add_row(CMD_TEXT, 8'h41, 1'b1, 8'h41, 1'b0);      // 'A' right after reset
    add_row(CMD_END,  8'hff, 1'b1, CHAR_NUL, 1'b1);   // end, byte ignored
    add_row(CMD_TEXT, 8'h00, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'hff, 1'b1, 8'hff, 1'b0);
    add_row(CMD_TEXT, 8'h2f, 1'b1, 8'h2f, 1'b0);      // just below '0'
    add_row(CMD_TEXT, 8'h3a, 1'b1, 8'h3a, 1'b0);      // just above '9'
    // number closed by end of text; digit in the ignored byte field
    add_row(CMD_TEXT, 8'h30, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'h37, 1'b0, 8'h00, 1'b0);
    add_row(CMD_END,  8'h35, 1'b0, 8'h00, 1'b0);
    // zero value
    add_row(CMD_TEXT, 8'h30, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'h30, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'h30, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'h20, 1'b0, 8'h00, 1'b0);
    // eleven nines: saturates and stays saturated
    repeat (11) add_row(CMD_TEXT, 8'h39, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TEXT, 8'h7a, 1'b0, 8'h00, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].t_ch, dir_tab[i].t_end);

    run_phase(0, 0, 30);
    hold_reqs++;                // long output hold while input keeps coming
    run_phase(0, 0, 80);
    run_phase(78, 0, 110);
    wait_drained();             // sender pause until everything is out
    run_phase(0, 78, 110);
    run_phase(25, 25, 120);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions and %0d results: %0d numbers converted, %0d end markers,",
             n_items, n_checked, n_flushes, n_ends);
    $display("%0d saturating digits, under no idling, sender gaps, receiver stalls and a long hold-off",
             sat_digits);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- decimal_to_hex_text_rewriter_unit.f -----
sv/d2h_pkg.sv
sv/d2h_ctrl.sv
sv/d2h_datapath.sv
sv/decimal_to_hex_text_rewriter_unit.sv
sv/d2h_checker.sv
verif/tb_decimal_to_hex_text_rewriter_unit.sv
